[rtl/core/pme_pkg.sv]
// Shared types, codes and defaults of the permutation mutation engine.
`default_nettype none
package pme_pkg;

  localparam int MAX_GENES_DEF = 256;
  localparam int GENE_BITS_DEF = 16;
  localparam int GENE_COUNT_W  = 9;
  localparam int APB_ADDR_W    = 3;

  localparam logic [2:0] REQ_WRITE  = 3'd0;
  localparam logic [2:0] REQ_READ   = 3'd1;
  localparam logic [2:0] REQ_INSERT = 3'd2;
  localparam logic [2:0] REQ_SWAP   = 3'd3;
  localparam logic [2:0] REQ_INVERT = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_SKIP  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // register index of gene_count, taken from paddr[2]
  localparam logic REG_GENE_COUNT = 1'b0;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  point_a;
    logic [7:0]  point_b;
    logic [15:0] gene_in;
  } pme_req_t;

  typedef struct packed {
    logic [15:0] gene_out;
    logic [1:0]  status;
  } pme_rsp_t;

endpackage
`default_nettype wire

[rtl/core/pme_gene_ram.sv]
// Gene store: one write port, one read port with registered read data.
`default_nettype none
module pme_gene_ram
  import pme_pkg::*;
#(
  parameter int MAX_GENES = MAX_GENES_DEF,
  parameter int GENE_BITS = GENE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(MAX_GENES)-1:0] rd_addr,
  output logic      [GENE_BITS-1:0]         rd_data,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(MAX_GENES)-1:0] wr_addr,
  input  wire logic [GENE_BITS-1:0]         wr_data
);

  logic [GENE_BITS-1:0] mem [MAX_GENES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/pme_ctrl.sv]
// Sequencer: checks requests and walks the gene store for each mutation.
`default_nettype none
module pme_ctrl
  import pme_pkg::*;
#(
  parameter int MAX_GENES = MAX_GENES_DEF,
  parameter int GENE_BITS = GENE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire pme_req_t                     req,
  output logic                              busy,
  output logic                              done,
  output pme_rsp_t                          rsp,
  input  wire logic [GENE_COUNT_W-1:0]      gene_count,
  output logic                              rd_en,
  output logic      [$clog2(MAX_GENES)-1:0] rd_addr,
  input  wire logic [GENE_BITS-1:0]         rd_data,
  output logic                              wr_en,
  output logic      [$clog2(MAX_GENES)-1:0] wr_addr,
  output logic      [GENE_BITS-1:0]         wr_data
);

  localparam int AW = $clog2(MAX_GENES);
  localparam logic [AW:0] SPAN_MIN = (AW + 1)'(2);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_WR       = 4'd1;
  localparam logic [3:0] S_RD       = 4'd2;
  localparam logic [3:0] S_RD2      = 4'd3;
  localparam logic [3:0] S_INS      = 4'd4;
  localparam logic [3:0] S_INS_TAIL = 4'd5;
  localparam logic [3:0] S_INS_FIN  = 4'd6;
  localparam logic [3:0] S_INV_A    = 4'd7;
  localparam logic [3:0] S_INV_B    = 4'd8;
  localparam logic [3:0] S_INV_DA   = 4'd9;
  localparam logic [3:0] S_INV_DB   = 4'd10;

  logic [3:0]           state;
  logic [AW-1:0]        a_idx;
  logic [AW-1:0]        b_idx;
  logic [GENE_BITS-1:0] gin;
  logic                 up;
  logic [AW-1:0]        rd_ptr;
  logic                 rv;
  logic [AW-1:0]        ra;
  logic [GENE_BITS-1:0] moving;
  logic [AW-1:0]        lo;
  logic [AW-1:0]        hi;
  logic [AW-1:0]        wlo;
  logic [AW-1:0]        whi;
  logic [GENE_BITS-1:0] t_lo;
  logic                 pend;
  logic                 single;

  logic                 in_a;
  logic                 in_b;
  logic                 short_len;
  logic [1:0]           chk_status;
  logic                 go;
  logic [AW:0]          span;

  assign busy = (state != S_IDLE);

  assign in_a = (9'(req.point_a) < gene_count) && (32'(req.point_a) < 32'(MAX_GENES));
  assign in_b = (9'(req.point_b) < gene_count) && (32'(req.point_b) < 32'(MAX_GENES));
  assign short_len = gene_count < 9'd2;
  assign span = {1'b0, hi} - {1'b0, lo};

  // classify the request at accept time
  always_comb begin
    chk_status = ST_DONE;
    go = 1'b0;
    case (req.req_type)
      REQ_WRITE, REQ_READ: begin
        if (in_a) begin
          go = 1'b1;
        end else begin
          chk_status = ST_RANGE;
        end
      end
      REQ_INSERT, REQ_SWAP, REQ_INVERT: begin
        if (short_len) begin
          chk_status = ST_SKIP;
        end else if (!in_a || !in_b) begin
          chk_status = ST_RANGE;
        end else if (req.point_a == req.point_b) begin
          chk_status = ST_SKIP;
        end else begin
          go = 1'b1;
        end
      end
      default: chk_status = ST_RANGE;
    endcase
  end

  // store port drive
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = a_idx;
    wr_en   = 1'b0;
    wr_addr = a_idx;
    wr_data = rd_data;
    case (state)
      S_WR: begin
        wr_en   = 1'b1;
        wr_data = gin;
      end
      S_RD: begin
        rd_en = 1'b1;
      end
      S_INS, S_INS_TAIL: begin
        rd_en   = (state == S_INS);
        rd_addr = rd_ptr;
        // shift each gene one place toward the origin
        if (rv && ra != a_idx) begin
          wr_en   = 1'b1;
          wr_addr = up ? ra - AW'(1) : ra + AW'(1);
        end
      end
      S_INS_FIN: begin
        wr_en   = 1'b1;
        wr_addr = b_idx;
        wr_data = moving;
      end
      S_INV_A: begin
        rd_en   = 1'b1;
        rd_addr = lo;
        wr_en   = pend;
        wr_addr = wlo;
      end
      S_INV_B: begin
        rd_en   = 1'b1;
        rd_addr = hi;
        wr_en   = pend;
        wr_addr = whi;
        wr_data = t_lo;
      end
      S_INV_DA: begin
        wr_en   = 1'b1;
        wr_addr = wlo;
      end
      S_INV_DB: begin
        wr_en   = 1'b1;
        wr_addr = whi;
        wr_data = t_lo;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      rv    <= 1'b0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            a_idx  <= AW'(req.point_a);
            b_idx  <= AW'(req.point_b);
            gin    <= GENE_BITS'(req.gene_in);
            up     <= req.point_a < req.point_b;
            rd_ptr <= AW'(req.point_a);
            rv     <= 1'b0;
            pend   <= 1'b0;
            single <= (req.req_type == REQ_SWAP);
            if (req.point_a < req.point_b) begin
              lo <= AW'(req.point_a);
              hi <= AW'(req.point_b);
            end else begin
              lo <= AW'(req.point_b);
              hi <= AW'(req.point_a);
            end
            if (!go) begin
              done         <= 1'b1;
              rsp.gene_out <= '0;
              rsp.status   <= chk_status;
            end else begin
              case (req.req_type)
                REQ_WRITE:  state <= S_WR;
                REQ_READ:   state <= S_RD;
                REQ_INSERT: state <= S_INS;
                default:    state <= S_INV_A;
              endcase
            end
          end
        end
        S_WR: begin
          done         <= 1'b1;
          rsp.gene_out <= '0;
          rsp.status   <= ST_DONE;
          state        <= S_IDLE;
        end
        S_RD: begin
          state <= S_RD2;
        end
        S_RD2: begin
          done         <= 1'b1;
          rsp.gene_out <= 16'(rd_data);
          rsp.status   <= ST_DONE;
          state        <= S_IDLE;
        end
        S_INS: begin
          rv <= 1'b1;
          ra <= rd_ptr;
          if (rv && ra == a_idx) begin
            moving <= rd_data;
          end
          if (rd_ptr == b_idx) begin
            state <= S_INS_TAIL;
          end else begin
            rd_ptr <= up ? rd_ptr + AW'(1) : rd_ptr - AW'(1);
          end
        end
        S_INS_TAIL: begin
          rv    <= 1'b0;
          state <= S_INS_FIN;
        end
        S_INS_FIN: begin
          done         <= 1'b1;
          rsp.gene_out <= '0;
          rsp.status   <= ST_DONE;
          state        <= S_IDLE;
        end
        S_INV_A: begin
          state <= S_INV_B;
        end
        S_INV_B: begin
          // hold the pair for write-back while the next pair is read
          t_lo <= rd_data;
          wlo  <= lo;
          whi  <= hi;
          pend <= 1'b1;
          if (!single && span > SPAN_MIN) begin
            lo    <= lo + AW'(1);
            hi    <= hi - AW'(1);
            state <= S_INV_A;
          end else begin
            state <= S_INV_DA;
          end
        end
        S_INV_DA: begin
          state <= S_INV_DB;
        end
        S_INV_DB: begin
          pend         <= 1'b0;
          done         <= 1'b1;
          rsp.gene_out <= '0;
          rsp.status   <= ST_DONE;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/permutation_mutation_engine_core.sv]
// Top level of the permutation mutation engine: APB register, sequencer and gene store.
//
// Usage:
//   A request transaction is taken at a rising edge with start high and busy low.
//   req_type selects write gene, read gene, insertion, swap or inversion.
//   Each request gives one result on rsp, marked by done for one cycle; the
//   receiver cannot stall, so results must be taken when done is high.
//   Steps from accept to done: a rejected or skipped request raises done at
//     the accept edge; a write passes S_WR, a read S_RD and S_RD2;
//     insertion: one gene read per cycle, each written one place
//     over on the following cycle, then the held gene written at b;
//     swap: one pair read and written; inversion: pairs from both ends inward
//     (reads of a pair overlap writes of the one before).
//   These steps are set by the single read port and single write port of
//   the gene store; one request is in flight at a time, and busy drops at the
//   same edge that raises done, so the next request may be taken during that strobe.
//   gene_count is written over APB at byte address 0; the user must do this only
//   while the block is idle, as the block does not enforce it. Reset clears
//   gene_count and the sequencer; gene store contents stay undefined until written.
`default_nettype none
module permutation_mutation_engine_core
  import pme_pkg::*;
#(
  parameter int MAX_GENES = MAX_GENES_DEF,
  parameter int GENE_BITS = GENE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire pme_req_t              req,
  output logic                       busy,
  output logic                       done,
  output pme_rsp_t                   rsp,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  localparam int AW = $clog2(MAX_GENES);

  logic [GENE_COUNT_W-1:0] gene_count;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic [GENE_BITS-1:0]    rd_data;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [GENE_BITS-1:0]    wr_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GENE_COUNT) ? 32'(gene_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gene_count <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_GENE_COUNT) begin
      gene_count <= pwdata[GENE_COUNT_W-1:0];
    end
  end

  pme_ctrl #(
    .MAX_GENES(MAX_GENES),
    .GENE_BITS(GENE_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req        (req),
    .busy       (busy),
    .done       (done),
    .rsp        (rsp),
    .gene_count (gene_count),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  pme_gene_ram #(
    .MAX_GENES(MAX_GENES),
    .GENE_BITS(GENE_BITS)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule
`default_nettype wire

[tb/pme_checker.sv]
// Response checker for the permutation mutation engine: shadow genome, prediction and compare.
`timescale 1ns / 100ps
module pme_checker
  import pme_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire pme_req_t              req,
  input  wire logic                  done,
  input  wire pme_rsp_t              rsp,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic                  pready,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  input  wire logic [31:0]           prdata,
  output int                         pending,
  output int                         errors,
  output int                         checked
);

  logic [GENE_BITS_DEF-1:0] genome [MAX_GENES_DEF];
  logic [GENE_COUNT_W-1:0]  gene_count;
  pme_rsp_t                 rsp_due_q [$];

  initial begin
    pending = 0;
    errors  = 0;
    checked = 0;
  end

  task automatic flag(input string msg);
    errors++;
    $display("[%0t] ERROR: %s", $time, msg);
  endtask

  // Apply one request to the shadow genome and work out its response.
  task automatic mutate_genome(input pme_req_t r, output pme_rsp_t resp);
    int unsigned len;
    int unsigned a;
    int unsigned b;
    int unsigned lo;
    int unsigned hi;
    int unsigned i;
    logic [GENE_BITS_DEF-1:0] held;
    len = (gene_count > MAX_GENES_DEF) ? MAX_GENES_DEF : gene_count;
    a = r.point_a;
    b = r.point_b;
    resp = '0;
    resp.status = ST_DONE;
    case (r.req_type)
      REQ_WRITE: begin
        if (a < len) genome[a] = r.gene_in;
        else resp.status = ST_RANGE;
      end
      REQ_READ: begin
        if (a < len) resp.gene_out = genome[a];
        else resp.status = ST_RANGE;
      end
      REQ_INSERT, REQ_SWAP, REQ_INVERT: begin
        // short genotype wins over range, range wins over equal points
        if (len < 2) begin
          resp.status = ST_SKIP;
        end else if (a >= len || b >= len) begin
          resp.status = ST_RANGE;
        end else if (a == b) begin
          resp.status = ST_SKIP;
        end else if (r.req_type == REQ_INSERT) begin
          held = genome[a];
          if (a > b) begin
            for (i = a; i > b; i--) genome[i] = genome[i - 1];
          end else begin
            for (i = a; i < b; i++) genome[i] = genome[i + 1];
          end
          genome[b] = held;
        end else if (r.req_type == REQ_SWAP) begin
          held = genome[a];
          genome[a] = genome[b];
          genome[b] = held;
        end else begin
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
          while (lo < hi) begin
            held = genome[lo];
            genome[lo] = genome[hi];
            genome[hi] = held;
            lo++;
            hi--;
          end
        end
      end
      default: resp.status = ST_RANGE;
    endcase
  endtask

  always @(posedge clk) begin
    pme_rsp_t want;
    if (rst) begin
      gene_count = '0;
      rsp_due_q.delete();
    end else begin
      // retire the older transaction first: a strobe may share an edge with the next accept
      if (done === 1'b1) begin
        if (rsp_due_q.size() == 0) begin
          flag("response strobe with no request outstanding");
        end else begin
          want = rsp_due_q.pop_front();
          checked++;
          if (rsp.gene_out !== want.gene_out)
            flag($sformatf("gene_out got %h want %h", rsp.gene_out, want.gene_out));
          if (rsp.status !== want.status)
            flag($sformatf("status got %0d want %0d", rsp.status, want.status));
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        mutate_genome(req, want);
        rsp_due_q.push_back(want);
      end
      if (psel && penable && pready && paddr[2] == REG_GENE_COUNT) begin
        if (pwrite) begin
          gene_count = pwdata[GENE_COUNT_W-1:0];
        end else if (prdata !== 32'(gene_count)) begin
          flag($sformatf("gene_count read %h want %h", prdata, gene_count));
        end
      end
    end
    pending = rsp_due_q.size();
  end

endmodule

[tb/testbench.sv]
// Top of the permutation mutation engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
  import pme_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam logic [APB_ADDR_W-1:0] GENE_COUNT_ADDR = '0;

  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  start   = 1'b0;
  pme_req_t              req     = '0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [31:0]           pwdata  = '0;
  logic                  busy;
  logic                  done;
  pme_rsp_t              rsp;
  logic [31:0]           prdata;
  logic                  pready;

  int          pending;
  int          errors;
  int          checked;
  int unsigned cycles      = 0;
  int unsigned issued      = 0;
  int unsigned settings    = 0;
  int unsigned cur_len     = 0;
  int unsigned filled_upto = 0;

  always #2 clk = ~clk;

  permutation_mutation_engine_core u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req     (req),
    .busy    (busy),
    .done    (done),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pme_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pending (pending),
    .errors  (errors),
    .checked (checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses outstanding", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic pme_req_t make_req(input logic [2:0] kind, input logic [7:0] a,
                                        input logic [7:0] b, input logic [15:0] gene);
    pme_req_t r;
    r.req_type = kind;
    r.point_a  = a;
    r.point_b  = b;
    r.gene_in  = gene;
    return r;
  endfunction

  // Mostly in-range points; on long genotypes keep most spans short.
  function automatic pme_req_t random_req(input int unsigned len);
    pme_req_t    r;
    int unsigned pick;
    int          near;
    pick = $urandom_range(99);
    if (pick < 18) r.req_type = REQ_WRITE;
    else if (pick < 36) r.req_type = REQ_READ;
    else if (pick < 55) r.req_type = REQ_INSERT;
    else if (pick < 74) r.req_type = REQ_SWAP;
    else if (pick < 94) r.req_type = REQ_INVERT;
    else r.req_type = 3'($urandom_range(7));
    if (len != 0 && $urandom_range(9) < 8) begin
      r.point_a = 8'($urandom_range(len - 1));
      r.point_b = 8'($urandom_range(len - 1));
      if (len > 32 && $urandom_range(3) != 0) begin
        near = int'(r.point_a) + int'($urandom_range(16)) - 8;
        if (near < 0) near = 0;
        if (near >= int'(len)) near = int'(len) - 1;
        r.point_b = 8'(near);
      end
    end else begin
      r.point_a = 8'($urandom_range(255));
      r.point_b = 8'($urandom_range(255));
    end
    if ($urandom_range(15) == 0) r.point_b = r.point_a;
    r.gene_in = 16'($urandom_range(16'hFFFF));
    return r;
  endfunction

  // Called right after a rising edge; returns at the edge that takes the transaction.
  task automatic issue(input pme_req_t r, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(negedge clk); while (busy);
    @(posedge clk);
    issued++;
  endtask

  // Drop start and hold until every outstanding response has been seen.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Program the length, read it back and load any genes not yet written.
  task automatic set_gene_count(input int unsigned value);
    drain();
    apb_access(1'b1, GENE_COUNT_ADDR, value);
    apb_access(1'b0, GENE_COUNT_ADDR, '0);
    settings++;
    cur_len = (value > MAX_GENES_DEF) ? MAX_GENES_DEF : value;
    while (filled_upto < cur_len) begin
      issue(make_req(REQ_WRITE, 8'(filled_upto), 8'd0, 16'($urandom_range(16'hFFFF))), 0);
      filled_upto++;
    end
  endtask

  initial begin
    int unsigned phase_count [10];
    int unsigned idle_pct [4];
    int unsigned idle;
    phase_count = '{2, 16, 256, 3, 511, 40, 0, 200, 5, 0};
    phase_count[9] = $urandom_range(511);
    idle_pct = '{0, 73, 0, 33};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty genotype: every access and undefined code out of range, every mutation skipped
    issue(make_req(REQ_WRITE, 8'd0, 8'd0, 16'hFFFF), 0);
    issue(make_req(REQ_READ, 8'd0, 8'd0, 16'h0000), 0);
    issue(make_req(REQ_READ, 8'd255, 8'd255, 16'h0000), 0);
    issue(make_req(REQ_INSERT, 8'd0, 8'd1, 16'h0000), 0);
    issue(make_req(REQ_SWAP, 8'd255, 8'd0, 16'h0000), 0);
    issue(make_req(REQ_INVERT, 8'd0, 8'd0, 16'h0000), 0);
    for (int k = int'(REQ_INVERT) + 1; k < 8; k++)
      issue(make_req(3'(k), 8'd0, 8'd0, 16'hFFFF), 0);

    // single gene: short genotype skip takes priority over range
    set_gene_count(1);
    issue(make_req(REQ_WRITE, 8'd0, 8'd0, 16'hFFFF), 0);
    issue(make_req(REQ_READ, 8'd0, 8'd0, 16'h0000), 0);
    issue(make_req(REQ_WRITE, 8'd1, 8'd0, 16'h1234), 0);
    issue(make_req(REQ_SWAP, 8'd0, 8'd0, 16'h0000), 0);
    issue(make_req(REQ_INVERT, 8'd0, 8'd255, 16'h0000), 0);

    // eight genes: range before equal points, both directions of insertion and inversion
    set_gene_count(8);
    issue(make_req(REQ_INSERT, 8'd0, 8'd8, 16'h0000), 0);
    issue(make_req(REQ_SWAP, 8'd200, 8'd3, 16'h0000), 0);
    issue(make_req(REQ_INVERT, 8'd8, 8'd8, 16'h0000), 0);
    issue(make_req(REQ_SWAP, 8'd3, 8'd3, 16'h0000), 0);
    issue(make_req(REQ_INSERT, 8'd1, 8'd6, 16'h0000), 0);
    issue(make_req(REQ_INSERT, 8'd6, 8'd1, 16'h0000), 0);
    issue(make_req(REQ_SWAP, 8'd0, 8'd7, 16'h0000), 0);
    issue(make_req(REQ_INVERT, 8'd7, 8'd0, 16'h0000), 0);
    issue(make_req(REQ_INVERT, 8'd2, 8'd5, 16'h0000), 0);
    issue(make_req(REQ_READ, 8'd7, 8'd0, 16'h0000), 0);
    issue(make_req(REQ_WRITE, 8'd7, 8'd0, 16'h0000), 0);

    // full store: spans over the whole genotype
    set_gene_count(MAX_GENES_DEF);
    issue(make_req(REQ_INSERT, 8'd0, 8'd255, 16'h0000), 0);
    issue(make_req(REQ_INSERT, 8'd255, 8'd0, 16'h0000), 0);
    issue(make_req(REQ_INVERT, 8'd0, 8'd255, 16'h0000), 0);
    issue(make_req(REQ_SWAP, 8'd255, 8'd0, 16'h0000), 0);
    issue(make_req(REQ_READ, 8'd255, 8'd0, 16'h0000), 0);
    issue(make_req(REQ_WRITE, 8'd255, 8'd0, 16'hFFFF), 0);
    issue(make_req(REQ_READ, 8'd255, 8'd0, 16'h0000), 0);

    for (int p = 0; p < 10; p++) begin
      set_gene_count(phase_count[p]);
      idle = idle_pct[p % 4];
      for (int k = 0; k < 86; k++) begin
        if (k == 43 || $urandom_range(63) == 0) drain();
        issue(random_req(cur_len), idle);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Drove %0d requests over %0d gene_count settings (0, 1, 2 up to 511).",
             issued, settings);
    $display("Compared %0d responses; writes, reads, all three mutations and bad codes.",
             checked);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
